FILE: hw/rtl/bpib_pkg.sv
// Bouncing point in box: shared types and constants.
// Used by bouncing_point_in_box_unit; no dependencies.
package bpib_pkg;

  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_FOLD_PASSES_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [DATA_W-1:0] BOX_WIDTH_RST  = 32'd6553600;
  localparam logic [DATA_W-1:0] BOX_HEIGHT_RST = 32'd3276800;
  localparam logic [DATA_W-1:0] START_PX_RST   = 32'd655360;
  localparam logic [DATA_W-1:0] START_PY_RST   = 32'd1310720;
  localparam logic [DATA_W-1:0] START_VX_RST   = 32'd1638400;
  localparam logic [DATA_W-1:0] START_VY_RST   = 32'd327680;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_WIDTH  = 3'd0,
    REG_BOX_HEIGHT = 3'd1,
    REG_START_PX   = 3'd2,
    REG_START_PY   = 3'd3,
    REG_START_VX   = 3'd4,
    REG_START_VY   = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_ADD_X,
    ST_MUL_Y,
    ST_ADD_Y,
    ST_CHECK,
    ST_FOLD,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    FS_X_NEAR = 2'd0,
    FS_X_FAR  = 2'd1,
    FS_Y_NEAR = 2'd2,
    FS_Y_FAR  = 2'd3
  } fold_step_t;

endpackage

FILE: hw/rtl/bouncing_point_in_box_unit.sv
// Bouncing point in box: top level, sequencer with one shared multiplier
// and one shared fold adder. Depends on bpib_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall, restart, step_time) takes one time
//   step per word. Output channel (out_valid/out_stall) returns one word per
//   step: position, velocity, overrun and setup_error.
//   Configuration is written through cfg_en/cfg_index/cfg_data while idle;
//   the user must keep to this, as the block itself does not enforce it.
// Sequence:
//   A step forms the displacement on one 32x32 multiplier, one axis at a
//   time (multiply, then add, x then y), then runs a bounds check and N fold
//   passes (0..MAX_FOLD_PASSES), each on the shared fold adder (near and far
//   wall, x then y) plus a bounds check. With a setup error the step goes
//   straight to ST_FIN. in_stall is high while a step is in work.
// Reset:
//   rst loads the default box and start registers and the start state.
// Stall:
//   A result waits in the output register; the next step may be accepted
//   and run, and it holds in its final cycle until the old word is taken.
module bouncing_point_in_box_unit
  import bpib_pkg::*;
#(
  parameter int MAX_FOLD_PASSES = MAX_FOLD_PASSES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     restart,
  input  logic [DATA_W-1:0]        step_time,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DATA_W-1:0]        pos_x,
  output logic [DATA_W-1:0]        pos_y,
  output logic signed [DATA_W-1:0] vel_x,
  output logic signed [DATA_W-1:0] vel_y,
  output logic                     overrun,
  output logic                     setup_error
);

  localparam int POS_W = PROD_W - FRAC_BITS + 2;
  localparam int PASS_W = $clog2(MAX_FOLD_PASSES + 1);
  localparam int EXT_W = POS_W - DATA_W;

  logic [DATA_W-1:0] box_width, box_height, start_px, start_py;
  logic signed [DATA_W-1:0] start_vx, start_vy;
  logic [DATA_W-1:0] cur_px, cur_py;
  logic signed [DATA_W-1:0] cur_vx, cur_vy;

  state_t state, state_next;
  fold_step_t fstep;
  logic [PASS_W-1:0] passes;
  logic [DATA_W-1:0] dt;
  logic [PROD_W-1:0] prod;
  logic signed [POS_W-1:0] px, py;
  logic signed [DATA_W-1:0] vx, vy;
  logic over, err;

  logic accept, setup_bad, load_out, out_take;
  logic axis_y;
  logic signed [DATA_W-1:0] v_sel, v_flip;
  logic [DATA_W-1:0] mag;
  logic [PROD_W-1:0] prod_full;
  logic signed [POS_W-1:0] p_sel, w_sel, disp, p_adv, p_fold;
  logic fold_hit;
  logic signed [POS_W-1:0] w_ext, h_ext;
  logic x_lo, x_hi, y_lo, y_hi, outside_any, pass_limit;

  assign accept = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign setup_bad = (box_width == '0) || (box_height == '0) ||
                     (start_px >= box_width) || (start_py >= box_height);

  assign w_ext = $signed({{EXT_W{1'b0}}, box_width});
  assign h_ext = $signed({{EXT_W{1'b0}}, box_height});

  // shared multiplier and adder operand select
  always_comb begin
    axis_y = (state == ST_MUL_Y) || (state == ST_ADD_Y) ||
             (fstep == FS_Y_NEAR) || (fstep == FS_Y_FAR);
    if (state == ST_MUL_X || state == ST_ADD_X) begin
      axis_y = 1'b0;
    end
    v_sel = axis_y ? vy : vx;
    p_sel = axis_y ? py : px;
    w_sel = axis_y ? h_ext : w_ext;
    v_flip = (v_sel == $signed({1'b1, {(DATA_W-1){1'b0}}})) ?
             $signed({1'b0, {(DATA_W-1){1'b1}}}) : -v_sel;
  end

  assign mag = v_sel[DATA_W-1] ? DATA_W'(-v_sel) : DATA_W'(v_sel);
  assign prod_full = mag * dt;
  assign disp = $signed({2'b00, prod[PROD_W-1:FRAC_BITS]});
  assign p_adv = v_sel[DATA_W-1] ? (p_sel - disp) : (p_sel + disp);

  // one fold step: near wall mirrors about 0, far wall about the wall
  always_comb begin
    p_fold = p_sel;
    fold_hit = 1'b0;
    if (fstep == FS_X_NEAR || fstep == FS_Y_NEAR) begin
      if (p_sel < 0) begin
        p_fold = -p_sel;
        fold_hit = 1'b1;
      end
    end else if (p_sel >= w_sel) begin
      fold_hit = 1'b1;
      if (p_sel == w_sel) begin
        p_fold = w_sel - POS_W'(1);
      end else begin
        p_fold = (w_sel <<< 1) - p_sel;
      end
    end
  end

  assign x_lo = px < 0;
  assign x_hi = px >= w_ext;
  assign y_lo = py < 0;
  assign y_hi = py >= h_ext;
  assign outside_any = x_lo || x_hi || y_lo || y_hi;
  assign pass_limit = passes == PASS_W'(MAX_FOLD_PASSES);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = setup_bad ? ST_FIN : ST_MUL_X;
      ST_MUL_X: state_next = ST_ADD_X;
      ST_ADD_X: state_next = ST_MUL_Y;
      ST_MUL_Y: state_next = ST_ADD_Y;
      ST_ADD_Y: state_next = ST_CHECK;
      ST_CHECK: state_next = (outside_any && !pass_limit) ? ST_FOLD : ST_FIN;
      ST_FOLD:  if (fstep == FS_Y_FAR) state_next = ST_CHECK;
      ST_FIN:   if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = state != ST_IDLE;
    load_out = (state == ST_FIN) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_width <= BOX_WIDTH_RST;
      box_height <= BOX_HEIGHT_RST;
      start_px <= START_PX_RST;
      start_py <= START_PY_RST;
      start_vx <= START_VX_RST;
      start_vy <= START_VY_RST;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_BOX_WIDTH:  box_width <= cfg_data;
        REG_BOX_HEIGHT: box_height <= cfg_data;
        REG_START_PX:   start_px <= cfg_data;
        REG_START_PY:   start_py <= cfg_data;
        REG_START_VX:   start_vx <= cfg_data;
        REG_START_VY:   start_vy <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        dt <= step_time;
        fstep <= FS_X_NEAR;
        passes <= '0;
        over <= 1'b0;
        err <= setup_bad;
        if (restart && !setup_bad) begin
          px <= $signed({{EXT_W{1'b0}}, start_px});
          py <= $signed({{EXT_W{1'b0}}, start_py});
          vx <= start_vx;
          vy <= start_vy;
        end else begin
          px <= $signed({{EXT_W{1'b0}}, cur_px});
          py <= $signed({{EXT_W{1'b0}}, cur_py});
          vx <= cur_vx;
          vy <= cur_vy;
        end
      end
      ST_MUL_X, ST_MUL_Y: prod <= prod_full;
      ST_ADD_X: px <= p_adv;
      ST_ADD_Y: py <= p_adv;
      ST_CHECK: begin
        fstep <= FS_X_NEAR;
        if (outside_any && !pass_limit) begin
          passes <= passes + PASS_W'(1);
        end else if (outside_any) begin
          over <= 1'b1;
          if (x_lo) px <= '0;
          else if (x_hi) px <= w_ext - POS_W'(1);
          if (y_lo) py <= '0;
          else if (y_hi) py <= h_ext - POS_W'(1);
        end
      end
      ST_FOLD: begin
        fstep <= fold_step_t'(fstep + 2'd1);
        if (axis_y) begin
          py <= p_fold;
          if (fold_hit) vy <= v_flip;
        end else begin
          px <= p_fold;
          if (fold_hit) vx <= v_flip;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_px <= START_PX_RST;
      cur_py <= START_PY_RST;
      cur_vx <= START_VX_RST;
      cur_vy <= START_VY_RST;
    end else if (load_out) begin
      cur_px <= px[DATA_W-1:0];
      cur_py <= py[DATA_W-1:0];
      cur_vx <= vx;
      cur_vy <= vy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pos_x <= px[DATA_W-1:0];
      pos_y <= py[DATA_W-1:0];
      vel_x <= vx;
      vel_y <= vy;
      overrun <= over;
      setup_error <= err;
    end
  end

endmodule

FILE: test/bouncing_point_in_box_unit_tb.sv
// Self-checking testbench for bouncing_point_in_box_unit: directed and random time steps,
// with an in-bench model of the fold and bounce arithmetic.
// Depends on bpib_pkg and the bouncing_point_in_box_unit RTL.
module bouncing_point_in_box_unit_tb;
  import bpib_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    logic [DATA_W-1:0]        pos_x;
    logic [DATA_W-1:0]        pos_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic                     overrun;
    logic                     setup_error;
  } point_state_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_en = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     restart = 1'b0;
  logic [DATA_W-1:0]        step_time = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [DATA_W-1:0]        pos_x;
  logic [DATA_W-1:0]        pos_y;
  logic signed [DATA_W-1:0] vel_x;
  logic signed [DATA_W-1:0] vel_y;
  logic                     overrun;
  logic                     setup_error;

  // box registers and point state as the block should hold them
  logic [DATA_W-1:0] box_w = BOX_WIDTH_RST;
  logic [DATA_W-1:0] box_h = BOX_HEIGHT_RST;
  logic [DATA_W-1:0] home_px = START_PX_RST;
  logic [DATA_W-1:0] home_py = START_PY_RST;
  logic [DATA_W-1:0] home_vx = START_VX_RST;
  logic [DATA_W-1:0] home_vy = START_VY_RST;
  logic [DATA_W-1:0] pt_px = START_PX_RST;
  logic [DATA_W-1:0] pt_py = START_PY_RST;
  logic [DATA_W-1:0] pt_vx = START_VX_RST;
  logic [DATA_W-1:0] pt_vy = START_VY_RST;

  point_state_t point_states_due[$];
  point_state_t due_word;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;
  int           hold_cycles = 0;

  always #1 clk = ~clk;

  bouncing_point_in_box_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_en(cfg_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .restart(restart),
    .step_time(step_time),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .vel_x(vel_x),
    .vel_y(vel_y),
    .overrun(overrun),
    .setup_error(setup_error)
  );

  function automatic longint flip_speed(input longint v);
    longint n;
    n = -v;
    return (n > 64'sd2147483647) ? 64'sd2147483647 : n;
  endfunction

  function automatic longint move_coord(input logic [DATA_W-1:0] pos, input longint vel,
                                        input logic [DATA_W-1:0] dt);
    longint unsigned mag;
    longint unsigned delta;
    mag = (vel < 0) ? -vel : vel;
    delta = (mag * {32'd0, dt}) >> FRAC_BITS_DEF;
    if (vel < 0)
      return longint'({32'd0, pos}) - longint'(delta);
    return longint'({32'd0, pos}) + longint'(delta);
  endfunction

  function automatic bit off_box(input longint p, input longint w);
    return p < 0 || p >= w;
  endfunction

  function automatic void reflect(inout longint p, inout longint v, input longint w);
    if (p < 0) begin
      p = -p;
      v = flip_speed(v);
    end
    if (p >= w) begin
      p = 2 * w - p;
      if (p == w)
        p = w - 1;
      v = flip_speed(v);
    end
  endfunction

  function automatic longint clamp_coord(input longint p, input longint w);
    if (p < 0)
      return 0;
    if (p >= w)
      return w - 1;
    return p;
  endfunction

  function automatic point_state_t next_point_state(input bit rs, input logic [DATA_W-1:0] dt);
    point_state_t r;
    longint w, h, px, py, vx, vy;
    int passes;
    bit bad;
    bad = box_w == 0 || box_h == 0 || home_px >= box_w || home_py >= box_h;
    r.overrun = 1'b0;
    if (!bad) begin
      w = longint'({32'd0, box_w});
      h = longint'({32'd0, box_h});
      if (rs) begin
        pt_px = home_px;
        pt_py = home_py;
        pt_vx = home_vx;
        pt_vy = home_vy;
      end
      vx = longint'($signed(pt_vx));
      vy = longint'($signed(pt_vy));
      px = move_coord(pt_px, vx, dt);
      py = move_coord(pt_py, vy, dt);
      passes = 0;
      while (passes < MAX_FOLD_PASSES_DEF && (off_box(px, w) || off_box(py, h))) begin
        reflect(px, vx, w);
        reflect(py, vy, h);
        passes++;
      end
      if (off_box(px, w) || off_box(py, h)) begin
        r.overrun = 1'b1;
        px = clamp_coord(px, w);
        py = clamp_coord(py, h);
      end
      pt_px = px[31:0];
      pt_py = py[31:0];
      pt_vx = vx[31:0];
      pt_vy = vy[31:0];
    end
    r.pos_x = pt_px;
    r.pos_y = pt_py;
    r.vel_x = pt_vx;
    r.vel_y = pt_vy;
    r.setup_error = bad;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [DATA_W-1:0] exp_v,
                                        input logic [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s expected %h got %h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (point_states_due.size() == 0) begin
        $error("result word with none expected");
        mismatches++;
      end else begin
        due_word = point_states_due.pop_front();
        compare_field("pos_x", due_word.pos_x, pos_x);
        compare_field("pos_y", due_word.pos_y, pos_y);
        compare_field("vel_x", due_word.vel_x, vel_x);
        compare_field("vel_y", due_word.vel_y, vel_y);
        compare_field("overrun", {31'd0, due_word.overrun}, {31'd0, overrun});
        compare_field("setup_error", {31'd0, due_word.setup_error}, {31'd0, setup_error});
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_step(input bit rs, input logic [DATA_W-1:0] dt);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart <= rs;
    step_time <= dt;
    do @(posedge clk); while (in_stall);
    point_states_due.push_back(next_point_state(rs, dt));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (point_states_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [DATA_W-1:0] v);
    cfg_en <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    case (r)
      REG_BOX_WIDTH:  box_w = v;
      REG_BOX_HEIGHT: box_h = v;
      REG_START_PX:   home_px = v;
      REG_START_PY:   home_py = v;
      REG_START_VX:   home_vx = v;
      REG_START_VY:   home_vy = v;
      default: ;
    endcase
  endtask

  task automatic load_box(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] h,
                          input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py,
                          input logic [DATA_W-1:0] vx, input logic [DATA_W-1:0] vy);
    wait_idle();
    write_reg(REG_BOX_WIDTH, w);
    write_reg(REG_BOX_HEIGHT, h);
    write_reg(REG_START_PX, px);
    write_reg(REG_START_PY, py);
    write_reg(REG_START_VX, vx);
    write_reg(REG_START_VY, vy);
    cfg_en <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_size();
    int unsigned r;
    logic [DATA_W-1:0] s;
    r = $urandom_range(99);
    if (r < 10)
      return $urandom_range(16, 1);
    if (r < 20) begin
      s = $urandom;
      return (s == 0) ? 32'd1 : s;
    end
    return $urandom_range(32'h0100_0000, 32'h0001_0000);
  endfunction

  function automatic logic [DATA_W-1:0] pick_speed(input logic [DATA_W-1:0] span);
    logic [DATA_W-1:0] mag;
    if ($urandom_range(99) < 10)
      return $urandom;
    mag = $urandom_range(span >> 1, 0);
    return $urandom_range(1) ? -mag : mag;
  endfunction

  function automatic logic [DATA_W-1:0] pick_dt();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5)
      return '0;
    if (r < 10)
      return $urandom;
    return $urandom_range(32'h0002_0000, 0);
  endfunction

  task automatic random_box();
    logic [DATA_W-1:0] w, h, px, py;
    int unsigned r;
    w = pick_size();
    h = pick_size();
    px = $urandom % w;
    py = $urandom % h;
    r = $urandom_range(99);
    if (r < 3)
      w = '0;
    else if (r < 5)
      h = '0;
    else if (r < 7)
      px = w;
    else if (r < 9)
      py = h;
    load_box(w, h, px, py, pick_speed(w), pick_speed(h));
  endtask

  task automatic test_default_box();
    send_step(1'b0, 32'h0000_0000);
    send_step(1'b0, 32'h0001_0000);
    send_step(1'b1, 32'hFFFF_FFFF);
    send_step(1'b1, 32'h0001_0000);
  endtask

  task automatic test_wall_hits();
    // x lands exactly on the far wall, y crosses the near wall
    load_box(32'h0064_0000, 32'h0032_0000, 32'h000A_0000, 32'h0001_0000,
             32'h0001_0000, 32'hFFFF_0000);
    send_step(1'b1, 32'h005A_0000);
    send_step(1'b0, 32'h0000_8000);
    // most negative speed saturates on its bounce
    load_box(32'h0064_0000, 32'h0032_0000, 32'h0000_4000, 32'h0031_C000,
             32'h8000_0000, 32'h7FFF_FFFF);
    send_step(1'b1, 32'h0000_0001);
    send_step(1'b0, 32'h0000_0001);
  endtask

  task automatic test_setup_errors();
    load_box(32'h0000_0000, 32'h0032_0000, '0, '0, 32'h0001_0000, 32'h0001_0000);
    send_step(1'b1, 32'h0001_0000);
    load_box(32'h0064_0000, 32'h0000_0000, '0, '0, 32'h0001_0000, 32'h0001_0000);
    send_step(1'b0, 32'h0001_0000);
    load_box(32'h0064_0000, 32'h0032_0000, 32'h0064_0000, '0, 32'h0001_0000, '0);
    send_step(1'b1, 32'h0001_0000);
    load_box(32'h0064_0000, 32'h0032_0000, '0, 32'h0032_0000, '0, 32'h0001_0000);
    send_step(1'b1, 32'h0001_0000);
    send_step(1'b0, 32'hFFFF_FFFF);
  endtask

  task automatic test_extremes();
    load_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, '0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_step(1'b1, 32'hFFFF_FFFF);
    send_step(1'b0, 32'h0000_0001);
    send_step(1'b1, 32'h0000_0000);
    // one-ulp box: every move ends on a wall
    load_box(32'd1, 32'd1, '0, '0, 32'h0000_0001, 32'hFFFF_FFFF);
    send_step(1'b1, 32'h0001_0000);
    send_step(1'b0, 32'hFFFF_FFFF);
  endtask

  task automatic test_backpressure();
    load_box(32'h0064_0000, 32'h0032_0000, 32'h000A_0000, 32'h0001_0000,
             32'h0001_0000, 32'hFFFF_0000);
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = HOLD_OFF_CYCLES;
    repeat (24) send_step($urandom_range(99) < 10, $urandom_range(32'h0004_0000, 0));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      repeat (4) begin
        random_box();
        send_step(1'b1, pick_dt());
        repeat (59) send_step($urandom_range(99) < 6, pick_dt());
      end
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_default_box();
    test_wall_hits();
    test_setup_errors();
    test_extremes();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0 && point_states_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: bouncing_point_in_box_unit.f
hw/rtl/bpib_pkg.sv
hw/rtl/bouncing_point_in_box_unit.sv
test/bouncing_point_in_box_unit_tb.sv
